FILE: src/grid_raycast_column_macros.svh
// Assertion macros for the column raycaster.
// Used by the top level only; expects clk and rst in scope.
`ifndef GRID_RAYCAST_COLUMN_MACROS_SVH
`define GRID_RAYCAST_COLUMN_MACROS_SVH

// Implication checked in the same cycle
`define GRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/grc_pkg.sv
// Shared types and constants of the column raycaster.
// No dependencies; imported by every module of the block but the divider.
`default_nettype none
package grc_pkg;

  // Item codes
  localparam logic [1:0] MODE_TILE    = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_RENDER  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 3'd6;

  // Arithmetic widths
  localparam int DVD_W   = 33;   // dividend and quotient of the divider
  localparam int DELTA_W = 47;   // step distance, up to 2^46
  localparam int CAMX_W  = 28;   // camera x, signed Q.16
  localparam int PROD_W  = 46;   // plane times camera x
  localparam int RAY_W   = 31;   // ray component, signed Q.16
  localparam logic [DELTA_W-1:0] DELTA_MAX = DELTA_W'(64'd1 << 46);
  localparam logic [DVD_W-1:0]   ONE_Q32   = DVD_W'(64'd1 << 32);
  localparam int PERP_MIN = 6554;
  localparam int ONE_Q16  = 65536;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  column;
    logic [4:0]  tile_x;
    logic [4:0]  tile_y;
    logic [7:0]  palette_index;
    logic [31:0] write_data;
  } grc_in_t;

  typedef struct packed {
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic [31:0] wall_color;
    logic        hit_side;
  } grc_result_t;

  typedef enum logic [1:0] {DIV_DX, DIV_DY, DIV_LH} grc_div_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic         accept;
    logic         clear_step;
    logic         div_start;
    grc_div_sel_t div_sel;
    logic         cap_camx;
    logic         mul_ray;
    logic         load_ray;
    logic         cap_dx;
    logic         cap_dy;
    logic         mul_side;
    logic         walk_step;
    logic         rd_final;
    logic         rd_pal;
    logic         cap_lh;
    logic         emit;
  } grc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic render_req;
    logic clear_last;
    logic div_done;
    logic rx_zero;
    logic ry_zero;
    logic walk_stop;
  } grc_status_t;

endpackage
`default_nettype wire

FILE: src/grid_raycast_column.sv
// Top level of the column raycaster: controller plus datapath.
// Depends on grc_pkg, grc_ctrl, grc_datapath and the assertion macros.
//
// A render item keeps busy high through ray setup, divisions and a grid walk of
// 1 to MAP_W+MAP_H+64 steps, and its result shows up in the same cycle in which
// busy drops. Three divisions run on the one shared restoring divider: the two
// step distances (each skipped for a zero ray component) and the line height;
// camera x comes from a reciprocal multiply. After reset the block clears both
// memories, one entry per cycle, over max(MAP_W*MAP_H, PALETTE_DEPTH) entries
// (1024 by default) with busy high. Write config registers only while no render
// is in progress. Each result is shown for a single cycle with result_valid and
// cannot be held off by the receiver.
`default_nettype none
`include "grid_raycast_column_macros.svh"
module grid_raycast_column #(
  parameter int SCREEN_W      = 640,
  parameter int SCREEN_H      = 480,
  parameter int MAP_W         = 32,
  parameter int MAP_H         = 32,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire grc_pkg::grc_in_t              item,
  input  wire logic                          cfg_we,
  input  wire logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [grc_pkg::CFG_W-1:0]     cfg_data,
  output logic                               result_valid,
  output grc_pkg::grc_result_t               result
);
  import grc_pkg::*;

  grc_cmd_t    cmd;
  grc_status_t status;

  grc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  grc_datapath #(
    .SCREEN_W      (SCREEN_W),
    .SCREEN_H      (SCREEN_H),
    .MAP_W         (MAP_W),
    .MAP_H         (MAP_H),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // Checks
  `GRC_ASSERT_SAME(a_result_frees_block, result_valid, !busy, "result while busy")
  `GRC_ASSERT_NEXT(a_single_result, result_valid, !result_valid, "result repeated")
  `GRC_ASSERT_NEXT(a_write_no_result, start && !busy && item.mode != MODE_RENDER, !result_valid && !busy, "write item gave result")
endmodule
`default_nettype wire

FILE: src/grc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for the step distances and the line height.
`default_nettype none
module grc_div #(
  parameter int DVD_W = 33,
  parameter int DSR_W = 54
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output logic                  done
);
  localparam int R_W   = DSR_W + 1;
  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo;
  logic [R_W-1:0]   rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [R_W-1:0]   trial;
  logic             ge;

  // One shift-subtract step
  assign trial = {rem[R_W-2:0], quo[DVD_W-1]};
  assign ge    = trial >= R_W'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      rem <= ge ? (trial - R_W'(dsr)) : trial;
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

FILE: src/grc_datapath.sv
// Datapath: config registers, tile map and palette memories, ray setup,
// grid walk and wall span. Depends on grc_pkg and grc_div.
`default_nettype none
module grc_datapath #(
  parameter int SCREEN_W      = 640,
  parameter int SCREEN_H      = 480,
  parameter int MAP_W         = 32,
  parameter int MAP_H         = 32,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire grc_pkg::grc_in_t               item,
  input  wire logic                           cfg_we,
  input  wire logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [grc_pkg::CFG_W-1:0]      cfg_data,
  input  wire grc_pkg::grc_cmd_t              cmd,
  output grc_pkg::grc_status_t                status,
  output grc_pkg::grc_result_t                result
);
  import grc_pkg::*;

  localparam int MAP_CELLS  = MAP_W * MAP_H;
  localparam int MAP_AW     = $clog2(MAP_CELLS);
  localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
  localparam int CLR_N      = (MAP_CELLS > PALETTE_DEPTH) ? MAP_CELLS : PALETTE_DEPTH;
  localparam int CLR_W      = $clog2(CLR_N);
  localparam int WALK_LIMIT = MAP_W + MAP_H + 64;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
  localparam int DIST_W     = DELTA_W + STEP_W;
  localparam int MAP_MAX    = (MAP_W > MAP_H) ? MAP_W : MAP_H;
  localparam int COORD_W    = $clog2(MAP_MAX + 33) + 1;
  localparam int ROW_W      = 36;
  localparam logic [DVD_W-1:0] LH_NUM = DVD_W'(SCREEN_H * ONE_Q16);
  // Camera x quotient col*2^17/SCREEN_W by reciprocal: exact for col < 1024
  localparam int          CAMX_SH  = 22;
  localparam logic [39:0] CAMX_RCP = 40'(((64'd1 << 39) + 64'(SCREEN_W) - 64'd1) /
                                         64'(SCREEN_W));

  // Configuration registers
  logic [20:0]        cam_x, cam_y;
  logic signed [17:0] dir_x, dir_y, pl_x, pl_y;
  logic signed [9:0]  pitch;

  // Ray and walk registers
  logic [9:0]                 col_q;
  logic signed [CAMX_W-1:0]   camx;
  logic signed [PROD_W-1:0]   prod_x, prod_y;
  logic signed [RAY_W-1:0]    rx, ry;
  logic signed [COORD_W-1:0]  mx, my;
  logic [15:0]                fx, fy;
  logic [DELTA_W-1:0]         dx, dy;
  logic [DIST_W-1:0]          sx, sy, perp;
  logic                       x_neg, y_neg, side, oob_q, fin_inb, pal_ok;
  logic [STEP_W-1:0]          steps;
  logic [7:0]                 tile_q;
  logic [31:0]                pal_q;
  logic [DVD_W-1:0]           lh;
  logic [CLR_W-1:0]           clr_cnt;

  // Memories
  logic [7:0]  tile_map [MAP_CELLS];
  logic [31:0] palette  [PALETTE_DEPTH];

  function automatic logic in_map(logic signed [COORD_W-1:0] x,
                                  logic signed [COORD_W-1:0] y);
    return (x >= 0) && (x < MAP_W) && (y >= 0) && (y < MAP_H);
  endfunction

  function automatic logic [MAP_AW-1:0] map_addr(logic signed [COORD_W-1:0] x,
                                                 logic signed [COORD_W-1:0] y);
    return MAP_AW'(x * MAP_H + y);
  endfunction

  function automatic logic [8:0] clamp_row(logic signed [ROW_W-1:0] v);
    if (v < 0) return '0;
    if (v >= SCREEN_H) return 9'(SCREEN_H - 1);
    return v[8:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= 21'd65536;
      cam_y <= 21'd65536;
      dir_x <= -18'sd65536;
      dir_y <= '0;
      pl_x  <= '0;
      pl_y  <= 18'sd43254;
      pitch <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_POS_X: cam_x <= cfg_data[20:0];
        CFG_CAMERA_POS_Y: cam_y <= cfg_data[20:0];
        CFG_VIEW_DIR_X:   dir_x <= cfg_data[17:0];
        CFG_VIEW_DIR_Y:   dir_y <= cfg_data[17:0];
        CFG_PLANE_X:      pl_x  <= cfg_data[17:0];
        CFG_PLANE_Y:      pl_y  <= cfg_data[17:0];
        CFG_PITCH_OFFSET: pitch <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Shared divider and its operand select
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DIST_W-1:0] div_dsr;
  logic              div_done;
  logic [RAY_W-1:0]  rx_abs, ry_abs;

  assign rx_abs = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
  assign ry_abs = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);

  always_comb begin
    case (cmd.div_sel)
      DIV_DX: begin
        div_dvd = ONE_Q32;
        div_dsr = DIST_W'(rx_abs);
      end
      DIV_DY: begin
        div_dvd = ONE_Q32;
        div_dsr = DIST_W'(ry_abs);
      end
      default: begin
        div_dvd = LH_NUM;
        div_dsr = perp;
      end
    endcase
  end

  grc_div #(.DVD_W(DVD_W), .DSR_W(DIST_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  // Camera x product: column times reciprocal of the screen width
  logic [49:0] camx_prod;

  assign camx_prod = 50'(col_q) * 50'(CAMX_RCP);

  // One grid step: nearer line wins, ties go to the y line
  logic                      x_first, cand_oob;
  logic signed [COORD_W-1:0] nmx, nmy, cand_x, cand_y;
  logic [16:0]               fpx, fpy;
  logic [63:0]               side_px, side_py;
  logic [DIST_W-1:0]         perp_raw;

  assign x_first  = sx < sy;
  assign nmx      = x_neg ? mx - 1'b1 : mx + 1'b1;
  assign nmy      = y_neg ? my - 1'b1 : my + 1'b1;
  assign cand_x   = x_first ? nmx : mx;
  assign cand_y   = x_first ? my : nmy;
  assign cand_oob = !in_map(cand_x, cand_y);

  // Distance to the first grid line follows the ray's sign directly
  assign fpx     = rx[RAY_W-1] ? {1'b0, fx} : (17'h10000 - {1'b0, fx});
  assign fpy     = ry[RAY_W-1] ? {1'b0, fy} : (17'h10000 - {1'b0, fy});
  assign side_px = 64'(fpx) * 64'(dx);
  assign side_py = 64'(fpy) * 64'(dy);
  assign perp_raw = side ? (sy - DIST_W'(dy)) : (sx - DIST_W'(dx));

  always_ff @(posedge clk) begin
    if (cmd.accept) col_q <= item.column;
    if (cmd.cap_camx) camx <= CAMX_W'(camx_prod >> CAMX_SH) - CAMX_W'(ONE_Q16);
    if (cmd.mul_ray) begin
      prod_x <= PROD_W'(pl_x) * PROD_W'(camx);
      prod_y <= PROD_W'(pl_y) * PROD_W'(camx);
    end
    if (cmd.load_ray) begin
      rx <= RAY_W'(dir_x) + RAY_W'(prod_x >>> 16);
      ry <= RAY_W'(dir_y) + RAY_W'(prod_y >>> 16);
      mx <= COORD_W'(cam_x[20:16]);
      my <= COORD_W'(cam_y[20:16]);
      fx <= cam_x[15:0];
      fy <= cam_y[15:0];
    end
    if (cmd.cap_dx) dx <= status.rx_zero ? DELTA_MAX : DELTA_W'(div_q);
    if (cmd.cap_dy) dy <= status.ry_zero ? DELTA_MAX : DELTA_W'(div_q);
    if (cmd.mul_side) begin
      x_neg <= rx[RAY_W-1];
      y_neg <= ry[RAY_W-1];
      side  <= 1'b1;
      sx    <= DIST_W'(side_px >> 16);
      sy    <= DIST_W'(side_py >> 16);
    end
    if (cmd.walk_step) begin
      if (x_first) begin
        sx   <= sx + DIST_W'(dx);
        side <= 1'b0;
      end else begin
        sy   <= sy + DIST_W'(dy);
        side <= 1'b1;
      end
      if (!cand_oob) begin
        mx <= cand_x;
        my <= cand_y;
      end
    end
    if (cmd.rd_final) begin
      fin_inb <= in_map(mx, my);
      perp    <= (perp_raw < DIST_W'(PERP_MIN)) ? DIST_W'(PERP_MIN) : perp_raw;
    end
    // a final tile outside the map reads as zero
    if (cmd.rd_pal) pal_ok <= !fin_inb || (32'(tile_q) < PALETTE_DEPTH);
    if (cmd.cap_lh) lh <= div_q;
  end

  // Walk control state
  always_ff @(posedge clk) begin
    if (rst) begin
      steps   <= '0;
      oob_q   <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (cmd.load_ray) begin
        steps <= '0;
        oob_q <= 1'b0;
      end else if (cmd.walk_step) begin
        steps <= steps + 1'b1;
        oob_q <= cand_oob;
      end
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Tile map: one write port, one registered read port
  logic             map_we, map_re;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [7:0]       map_wdata;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = MAP_AW'(item.tile_x * MAP_H + item.tile_y);
    map_wdata = item.write_data[7:0];
    if (cmd.clear_step) begin
      map_we    = 32'(clr_cnt) < MAP_CELLS;
      map_waddr = clr_cnt[MAP_AW-1:0];
      map_wdata = '0;
    end else if (cmd.accept && item.mode == MODE_TILE) begin
      map_we = (32'(item.tile_x) < MAP_W) && (32'(item.tile_y) < MAP_H);
    end
    map_re    = cmd.walk_step || cmd.rd_final;
    map_raddr = cmd.walk_step ? map_addr(cand_x, cand_y) : map_addr(mx, my);
  end

  always_ff @(posedge clk) begin
    if (map_we) tile_map[map_waddr] <= map_wdata;
    if (map_re) tile_q <= tile_map[map_raddr];
  end

  // Palette: one write port, one registered read port
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [31:0]       pal_wdata;

  always_comb begin
    pal_we    = 1'b0;
    pal_waddr = item.palette_index[PAL_AW-1:0];
    pal_wdata = item.write_data;
    if (cmd.clear_step) begin
      pal_we    = 32'(clr_cnt) < PALETTE_DEPTH;
      pal_waddr = clr_cnt[PAL_AW-1:0];
      pal_wdata = '0;
    end else if (cmd.accept && item.mode == MODE_PALETTE) begin
      pal_we = 32'(item.palette_index) < PALETTE_DEPTH;
    end
    pal_raddr = fin_inb ? tile_q[PAL_AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (pal_we) palette[pal_waddr] <= pal_wdata;
    if (cmd.rd_pal) pal_q <= palette[pal_raddr];
  end

  // Wall span and result register
  logic signed [ROW_W-1:0] half_s, mid_s, pitch_s;

  assign half_s  = signed'(ROW_W'(lh >> 1));
  assign mid_s   = ROW_W'(SCREEN_H / 2);
  assign pitch_s = ROW_W'(pitch);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.draw_start <= clamp_row(mid_s - half_s + pitch_s);
      result.draw_end   <= clamp_row(mid_s + half_s + pitch_s);
      result.wall_color <= pal_ok ? pal_q : 32'd0;
      result.hit_side   <= side;
    end
  end

  // Status
  assign status.render_req = item.mode == MODE_RENDER;
  assign status.clear_last = clr_cnt == CLR_W'(CLR_N - 1);
  assign status.div_done   = div_done;
  assign status.rx_zero    = rx == '0;
  assign status.ry_zero    = ry == '0;
  assign status.walk_stop  = oob_q || (tile_q != 8'd0) || (steps == STEP_W'(WALK_LIMIT));
endmodule
`default_nettype wire

FILE: src/grc_ctrl.sv
// Controller: sequences clearing, ray setup, divisions and the grid walk.
// Depends on grc_pkg; drives the datapath through grc_cmd_t.
`default_nettype none
module grc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire grc_pkg::grc_status_t status,
  output grc_pkg::grc_cmd_t         cmd,
  output logic                      busy,
  output logic                      result_valid
);
  import grc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAMX, S_RAY_MUL, S_RAY_ADD,
    S_DX_GO, S_DX_W, S_DY_GO, S_DY_W, S_SIDE, S_STEP0, S_WALK,
    S_FTILE, S_FPAL, S_LH_W, S_EMIT
  } state_t;

  state_t state, state_next;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_DX;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = start;
        if (start && status.render_req) state_next = S_CAMX;
      end
      S_CAMX: begin
        cmd.cap_camx = 1'b1;
        state_next   = S_RAY_MUL;
      end
      S_RAY_MUL: begin
        cmd.mul_ray = 1'b1;
        state_next  = S_RAY_ADD;
      end
      S_RAY_ADD: begin
        cmd.load_ray = 1'b1;
        state_next   = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.div_sel = DIV_DX;
        if (status.rx_zero) begin
          cmd.cap_dx = 1'b1;
          state_next = S_DY_GO;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DX_W;
        end
      end
      S_DX_W: begin
        cmd.div_sel = DIV_DX;
        cmd.cap_dx  = status.div_done;
        if (status.div_done) state_next = S_DY_GO;
      end
      S_DY_GO: begin
        cmd.div_sel = DIV_DY;
        if (status.ry_zero) begin
          cmd.cap_dy = 1'b1;
          state_next = S_SIDE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DY_W;
        end
      end
      S_DY_W: begin
        cmd.div_sel = DIV_DY;
        cmd.cap_dy  = status.div_done;
        if (status.div_done) state_next = S_SIDE;
      end
      S_SIDE: begin
        cmd.mul_side = 1'b1;
        state_next   = S_STEP0;
      end
      S_STEP0: begin
        cmd.walk_step = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        // tile of the last step is in hand: stop on hit, edge or limit
        if (status.walk_stop) state_next = S_FTILE;
        else cmd.walk_step = 1'b1;
      end
      S_FTILE: begin
        cmd.rd_final = 1'b1;
        state_next   = S_FPAL;
      end
      S_FPAL: begin
        cmd.rd_pal    = 1'b1;
        cmd.div_sel   = DIV_LH;
        cmd.div_start = 1'b1;
        state_next    = S_LH_W;
      end
      S_LH_W: begin
        cmd.div_sel = DIV_LH;
        cmd.cap_lh  = status.div_done;
        if (status.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= state == S_EMIT;
    end
  end

  assign busy = state != S_IDLE;
endmodule
`default_nettype wire

FILE: bench/grid_raycast_column_check.sv
// Checker for the column raycaster: watches the item, config and result ports,
// predicts each rendered column and compares it. Depends on grc_pkg only.
`default_nettype none
module grid_raycast_column_check
  import grc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire grc_in_t              item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 result_valid,
  input  wire grc_result_t          result,
  output int                        fails,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int GRID  = 32;
  localparam int STEPS = GRID + GRID + 64;

  // Shadow of the block's state
  logic [7:0]  tiles [GRID*GRID];
  logic [31:0] colors [256];
  longint unsigned pos_x, pos_y;
  longint dir_x, dir_y, pl_x, pl_y, pitch;

  grc_result_t columns_due[$];

  assign pending = columns_due.size();

  function automatic logic [7:0] tile_at(int x, int y);
    if (x < 0 || x >= GRID || y < 0 || y >= GRID) return 8'd0;
    return tiles[x*GRID + y];
  endfunction

  // Q.16 step distance; a zero component gives the maximum
  function automatic longint unsigned stride(longint r);
    longint unsigned a;
    if (r == 0) return 64'd1 << 46;
    a = (r < 0) ? longint'(-r) : r;
    return (64'd1 << 32) / a;
  endfunction

  function automatic logic [8:0] row_clamp(longint v);
    if (v < 0) v = 0;
    if (v >= SCR_H) v = SCR_H - 1;
    return 9'(v);
  endfunction

  // Ray setup, DDA walk and wall span of one column
  function automatic grc_result_t cast_column(logic [9:0] col);
    longint camx, rx, ry, half;
    longint unsigned dx, dy, sx, sy, fx, fy, perp, lh;
    int mx, my, stx, sty, side;
    grc_result_t r;
    camx = longint'((64'd2 * col * 64'd65536) / 64'd640) - 65536;
    rx = dir_x + ((pl_x * camx) >>> 16);
    ry = dir_y + ((pl_y * camx) >>> 16);
    mx = int'(pos_x >> 16);
    my = int'(pos_y >> 16);
    fx = pos_x & 64'hFFFF;
    fy = pos_y & 64'hFFFF;
    dx = stride(rx);
    dy = stride(ry);
    side = 1;
    if (rx < 0) begin
      stx = -1; sx = (fx * dx) >> 16;
    end else begin
      stx = 1;  sx = ((64'd65536 - fx) * dx) >> 16;
    end
    if (ry < 0) begin
      sty = -1; sy = (fy * dy) >> 16;
    end else begin
      sty = 1;  sy = ((64'd65536 - fy) * dy) >> 16;
    end
    for (int n = 0; n < STEPS; n++) begin
      if (sx < sy) begin
        sx += dx; mx += stx; side = 0;
      end else begin
        sy += dy; my += sty; side = 1;
      end
      // left the map: back up to the last tile inside
      if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) begin
        if (side == 0) mx -= stx;
        else my -= sty;
        break;
      end
      if (tile_at(mx, my) != 0) break;
    end
    perp = (side == 0) ? sx - dx : sy - dy;
    if (perp < 6554) perp = 6554;
    lh = (64'd480 * 64'd65536) / perp;
    half = longint'(lh / 2);
    r.draw_start = row_clamp(-half + SCR_H/2 + pitch);
    r.draw_end   = row_clamp(half + SCR_H/2 + pitch);
    r.wall_color = colors[tile_at(mx, my)];
    r.hit_side   = side[0];
    return r;
  endfunction

  // Track config, state and accepted items
  always @(posedge clk) begin
    if (rst) begin
      foreach (tiles[i]) tiles[i] = '0;
      foreach (colors[i]) colors[i] = '0;
      pos_x = 65536; pos_y = 65536;
      dir_x = -65536; dir_y = 0;
      pl_x = 0; pl_y = 43254;
      pitch = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAMERA_POS_X: pos_x = cfg_data;
          CFG_CAMERA_POS_Y: pos_y = cfg_data;
          CFG_VIEW_DIR_X:   dir_x = longint'($signed(cfg_data[17:0]));
          CFG_VIEW_DIR_Y:   dir_y = longint'($signed(cfg_data[17:0]));
          CFG_PLANE_X:      pl_x  = longint'($signed(cfg_data[17:0]));
          CFG_PLANE_Y:      pl_y  = longint'($signed(cfg_data[17:0]));
          CFG_PITCH_OFFSET: pitch = longint'($signed(cfg_data[9:0]));
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (item.mode)
          MODE_TILE:    tiles[item.tile_x*GRID + item.tile_y] = item.write_data[7:0];
          MODE_PALETTE: colors[item.palette_index] = item.write_data;
          MODE_RENDER:  columns_due.push_back(cast_column(item.column));
          default: ;
        endcase
      end
    end
  end

  // Compare results against the oldest prediction
  initial fails = 0;
  always @(posedge clk) begin
    grc_result_t exp_col;
    if (!rst && result_valid) begin
      if (columns_due.size() == 0) begin
        $display("%0t: unexpected column result %h", $time, result);
        fails++;
      end else begin
        exp_col = columns_due.pop_front();
        if (result.draw_start !== exp_col.draw_start) begin
          $display("%0t: draw_start exp %0d got %0d", $time, exp_col.draw_start,
                   result.draw_start);
          fails++;
        end
        if (result.draw_end !== exp_col.draw_end) begin
          $display("%0t: draw_end exp %0d got %0d", $time, exp_col.draw_end,
                   result.draw_end);
          fails++;
        end
        if (result.wall_color !== exp_col.wall_color) begin
          $display("%0t: wall_color exp %h got %h", $time, exp_col.wall_color,
                   result.wall_color);
          fails++;
        end
        if (result.hit_side !== exp_col.hit_side) begin
          $display("%0t: hit_side exp %0d got %0d", $time, exp_col.hit_side,
                   result.hit_side);
          fails++;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: bench/grid_raycast_column_tb.sv
// Testbench top for the column raycaster: clock, reset, config phases and items.
// Depends on grc_pkg, grid_raycast_column and grid_raycast_column_check.
`default_nettype none
module grid_raycast_column_tb;
  import grc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN = 500;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic busy, result_valid;
  grc_in_t item = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  grc_result_t result;
  int fails, pending;
  int cycles = 0;
  bit no_gaps = 0;

  grid_raycast_column i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  grid_raycast_column_check i_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result),
    .fails(fails), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_raycast_column: mismatch");
      $finish;
    end
  end

  // Present one item, hold until taken, then maybe go quiet
  task automatic put(grc_in_t x);
    int gap;
    item = x;
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = no_gaps ? 0 : ($urandom_range(9) == 0 ? $urandom_range(60, 10)
                                                : $urandom_range(2));
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic tile_item(int x, int y, logic [31:0] d);
    grc_in_t x_it;
    x_it = '0;
    x_it.mode = MODE_TILE; x_it.tile_x = 5'(x); x_it.tile_y = 5'(y);
    x_it.column = 10'($urandom); x_it.palette_index = 8'($urandom);
    x_it.write_data = d;
    put(x_it);
  endtask

  task automatic color_item(int idx, logic [31:0] d);
    grc_in_t x_it;
    x_it = '0;
    x_it.mode = MODE_PALETTE; x_it.palette_index = 8'(idx);
    x_it.tile_x = 5'($urandom); x_it.tile_y = 5'($urandom);
    x_it.write_data = d;
    put(x_it);
  endtask

  task automatic column_item(int col);
    grc_in_t x_it;
    x_it = '0;
    x_it.mode = MODE_RENDER; x_it.column = 10'(col);
    x_it.tile_x = 5'($urandom); x_it.palette_index = 8'($urandom);
    x_it.write_data = $urandom;
    put(x_it);
  endtask

  // Wait until the block has drained, then let it settle
  task automatic drain();
    start = 0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we = 1; cfg_index = idx; cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_view(int px, int py, int dx, int dy, int plx, int ply, int pit);
    write_reg(CFG_CAMERA_POS_X, px);
    write_reg(CFG_CAMERA_POS_Y, py);
    write_reg(CFG_VIEW_DIR_X, dx);
    write_reg(CFG_VIEW_DIR_Y, dy);
    write_reg(CFG_PLANE_X, plx);
    write_reg(CFG_PLANE_Y, ply);
    write_reg(CFG_PITCH_OFFSET, pit);
  endtask

  function automatic int rnd_vec();
    return $urandom_range(3) == 0 ? int'($urandom_range(262143)) - 131072
                                  : int'($urandom_range(100000)) - 50000;
  endfunction

  // Random mix: renders, sparse map writes, palette writes, unused mode
  task automatic random_phase(int n);
    int k;
    grc_in_t x_it;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) no_gaps = ($urandom_range(3) == 0);
      k = $urandom_range(99);
      if (k < 45)
        column_item($urandom_range(7) == 0 ? $urandom_range(1023) : $urandom_range(639));
      else if (k < 75)
        tile_item($urandom_range(31), $urandom_range(31),
                  $urandom_range(2) == 0 ? $urandom : ($urandom & 32'hFFFF_FF00));
      else if (k < 95)
        color_item($urandom_range(255), $urandom);
      else begin
        x_it = grc_in_t'({$urandom, $urandom});
        x_it.mode = MODE_UNUSED;
        put(x_it);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed: empty map at reset config, edges, zero ray component
    column_item(0);
    column_item(320);
    column_item(639);
    column_item(1023);
    color_item(0, 32'hFFFF_FFFF);
    color_item(255, 32'h8000_0001);
    color_item(7, 32'h00A5_5A00);
    tile_item(0, 0, 32'hFFFF_FFFF);
    tile_item(31, 31, 32'h0000_0007);
    for (int y = 0; y < 32; y += 4) tile_item(0, y, 32'h1234_5607);
    begin
      grc_in_t x_it;
      x_it = '1;
      x_it.mode = MODE_UNUSED;
      put(x_it);
    end
    column_item(0);
    column_item(320);
    column_item(639);
    column_item(1023);
    drain();

    // Config extremes, then random settings
    set_view(0, 0, 131071, 131071, -131072, 131071, 480);
    random_phase(90);
    drain();
    set_view(2097151, 2097151, -131072, -131072, 131071, -131072, -480);
    random_phase(90);
    drain();
    set_view(5 << 16, 20 << 16, 0, 65536, 43254, 0, 0);
    random_phase(60);
    // Sender holds off until every column is back
    start = 0;
    while (pending != 0) @(negedge clk);
    random_phase(40);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_view($urandom_range(2097151), $urandom_range(2097151), rnd_vec(), rnd_vec(),
               rnd_vec(), rnd_vec(), int'($urandom_range(960)) - 480);
      random_phase(90);
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("grid_raycast_column: match");
    end else begin
      $display("grid_raycast_column: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/grc_pkg.sv
src/grc_div.sv
src/grc_datapath.sv
src/grc_ctrl.sv
src/grid_raycast_column.sv
bench/grid_raycast_column_check.sv
bench/grid_raycast_column_tb.sv
